// ----- rtl/stable_pose_offset_calibrator_defines.svh -----
// ----------------------------------------------------------------------------
// stable pose offset calibrator assertion macros
// concurrent checks clocked on clk, held off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef STABLE_POSE_OFFSET_CALIBRATOR_DEFINES_SVH
`define STABLE_POSE_OFFSET_CALIBRATOR_DEFINES_SVH

// same-cycle implication
`define SPOC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spoc check failed");

// next-cycle implication
`define SPOC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spoc check failed");

`endif

// ----- rtl/spoc_pkg.sv -----
// ----------------------------------------------------------------------------
// spoc_pkg
// shared widths, constants and types of the stable pose offset calibrator
// ----------------------------------------------------------------------------
package spoc_pkg;

	localparam int SAMPLES_TO_AVERAGE = 64;

	localparam int ANGLE_W  = 25;
	localparam int ORI_W    = 3;
	localparam int THR_W    = 20;
	localparam int OFF_W    = 26;
	localparam int MASK_W   = 3;
	localparam int STATUS_W = 2;
	localparam int AXES     = 3;
	localparam int AXIS_W   = 2;

	localparam int LOG_N  = $clog2(SAMPLES_TO_AVERAGE);
	localparam int CNT_W  = $clog2(SAMPLES_TO_AVERAGE + 1);
	localparam int SUM_W  = ANGLE_W + LOG_N;
	localparam int X_W    = SUM_W;
	localparam int Q_W    = X_W - LOG_N + 1;
	localparam int PROD_W = X_W + Q_W;
	localparam int AVG_W  = ANGLE_W + 1;
	localparam int CALC_W = OFF_W + 1;

	// floor(2^X_W / N): quotient estimate is exact or one short
	localparam logic [Q_W-1:0] DIV_RECIP = Q_W'((64'd1 << X_W) / SAMPLES_TO_AVERAGE);
	localparam logic [X_W-1:0] HALF_N    = X_W'(SAMPLES_TO_AVERAGE / 2);
	localparam logic [X_W:0]   DIV_N     = (X_W + 1)'(SAMPLES_TO_AVERAGE);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_TO_AVERAGE - 1);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(1311);

	localparam int DEG = 65536;
	localparam logic signed [CALC_W-1:0] DEG_P90    = CALC_W'(90 * DEG);
	localparam logic signed [CALC_W-1:0] DEG_M90    = CALC_W'(-90 * DEG);
	localparam logic signed [CALC_W-1:0] DEG_P180   = CALC_W'(180 * DEG);
	localparam logic signed [CALC_W-1:0] DEG_M180   = CALC_W'(-180 * DEG);
	localparam logic signed [CALC_W-1:0] OFF_LIM_P  = CALC_W'(360 * DEG);
	localparam logic signed [CALC_W-1:0] OFF_LIM_M  = CALC_W'(-360 * DEG);

	// orientation codes by the offset rule they select
	localparam logic [ORI_W-1:0] ORI_Z_P90  = 3'd0;
	localparam logic [ORI_W-1:0] ORI_Z_ZERO = 3'd1;
	localparam logic [ORI_W-1:0] ORI_XY_ZERO = 3'd2;
	localparam logic [ORI_W-1:0] ORI_Z_M90  = 3'd3;
	localparam logic [ORI_W-1:0] ORI_Z_HALF = 3'd4;
	localparam logic [ORI_W-1:0] ORI_XY_HALF = 3'd5;

	localparam logic [MASK_W-1:0] MASK_NONE = 3'b000;
	localparam logic [MASK_W-1:0] MASK_XY   = 3'b011;
	localparam logic [MASK_W-1:0] MASK_Z    = 3'b100;

	localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
	localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

	// stream packing
	localparam int IN_FIELDS_W  = AXES * ANGLE_W + ORI_W;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int ORI_LSB      = AXES * ANGLE_W;
	localparam int OUT_FIELDS_W = AXES * OFF_W + MASK_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int MASK_LSB     = AXES * OFF_W;

	typedef enum logic [STATUS_W-1:0] {
		ST_COLLECT  = 2'd0,
		ST_RESTART  = 2'd1,
		ST_ABORT    = 2'd2,
		ST_COMPLETE = 2'd3
	} spoc_status_t;

	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic signed [AVG_W-1:0]   avg_t;
	typedef logic signed [OFF_W-1:0]   offset_t;

	typedef struct packed {
		spoc_status_t     status;
		logic [ORI_W-1:0] ori;
	} spoc_res_t;

endpackage

// ----- rtl/spoc_core.sv -----
// ----------------------------------------------------------------------------
// spoc_core
// run state, motion and orientation checks, per-axis accumulation
// ----------------------------------------------------------------------------
module spoc_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic [spoc_pkg::THR_W-1:0]    threshold,
	input  spoc_pkg::angle_t              angle [spoc_pkg::AXES],
	input  logic [spoc_pkg::ORI_W-1:0]    ori,
	output spoc_pkg::spoc_res_t           res,
	output spoc_pkg::sum_t                sum_out [spoc_pkg::AXES]
);

	logic [spoc_pkg::CNT_W-1:0] cnt_q;
	logic [spoc_pkg::ORI_W-1:0] ref_ori_q;
	spoc_pkg::angle_t           ref_q [spoc_pkg::AXES];
	spoc_pkg::sum_t             sum_q [spoc_pkg::AXES];

	logic                              first;
	logic                              abort;
	logic                              moved;
	logic                              last;
	logic [spoc_pkg::ORI_W-1:0]        ref_ori_eff;
	logic [spoc_pkg::AXIS_W-1:0]       gaxis;
	spoc_pkg::angle_t                  ref_eff [spoc_pkg::AXES];
	logic signed [spoc_pkg::ANGLE_W:0] diff [spoc_pkg::AXES];
	logic [spoc_pkg::ANGLE_W:0]        dmag [spoc_pkg::AXES];
	logic [spoc_pkg::AXES-1:0]         axis_moved;
	spoc_pkg::sum_t                    sum_add [spoc_pkg::AXES];

	assign first       = (cnt_q == '0);
	assign ref_ori_eff = first ? ori : ref_ori_q;
	assign abort       = !first && (ori != ref_ori_q);
	assign last        = (cnt_q == spoc_pkg::CNT_LAST);

	// gravity axis is the code mod 3
	always_comb begin
		case (ref_ori_eff)
			3'd0, 3'd3, 3'd6: gaxis = spoc_pkg::AXIS_X;
			3'd1, 3'd4, 3'd7: gaxis = spoc_pkg::AXIS_Y;
			default:          gaxis = spoc_pkg::AXIS_Z;
		endcase
	end

	for (genvar g = 0; g < spoc_pkg::AXES; g++) begin : g_axis
		assign ref_eff[g] = first ? angle[g] : ref_q[g];
		assign diff[g]    = (spoc_pkg::ANGLE_W + 1)'(angle[g])
			- (spoc_pkg::ANGLE_W + 1)'(ref_eff[g]);
		assign dmag[g]    = diff[g][spoc_pkg::ANGLE_W]
			? unsigned'((spoc_pkg::ANGLE_W + 1)'(-diff[g]))
			: unsigned'(diff[g]);
		assign axis_moved[g] = (spoc_pkg::AXIS_W'(g) != gaxis)
			&& (dmag[g] > (spoc_pkg::ANGLE_W + 1)'(threshold));
		assign sum_add[g] = sum_q[g] + spoc_pkg::SUM_W'(angle[g]);
		assign sum_out[g] = sum_add[g];
	end

	assign moved = |axis_moved;

	always_comb begin
		res.ori = ref_ori_eff;
		if (abort) begin
			res.status = spoc_pkg::ST_ABORT;
		end else if (moved) begin
			res.status = spoc_pkg::ST_RESTART;
		end else if (last) begin
			res.status = spoc_pkg::ST_COMPLETE;
		end else begin
			res.status = spoc_pkg::ST_COLLECT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			ref_ori_q <= '0;
			for (int i = 0; i < spoc_pkg::AXES; i++) begin
				ref_q[i] <= '0;
				sum_q[i] <= '0;
			end
		end else if (fire) begin
			ref_ori_q <= ref_ori_eff;
			if (abort) begin
				cnt_q <= '0;
				for (int i = 0; i < spoc_pkg::AXES; i++) begin
					sum_q[i] <= '0;
				end
			end else if (moved) begin
				// this sample opens a new run
				cnt_q <= spoc_pkg::CNT_ONE;
				for (int i = 0; i < spoc_pkg::AXES; i++) begin
					ref_q[i] <= angle[i];
					sum_q[i] <= spoc_pkg::SUM_W'(angle[i]);
				end
			end else begin
				for (int i = 0; i < spoc_pkg::AXES; i++) begin
					if (first) begin
						ref_q[i] <= angle[i];
					end
					sum_q[i] <= last ? '0 : sum_add[i];
				end
				cnt_q <= last ? '0 : cnt_q + spoc_pkg::CNT_ONE;
			end
		end
	end

endmodule

// ----- rtl/spoc_div.sv -----
// ----------------------------------------------------------------------------
// spoc_div
// rounded average of one axis sum: reciprocal multiply, then one correction
// ----------------------------------------------------------------------------
module spoc_div (
	input  logic           clk,
	input  logic           en_s3,
	input  logic           en_s4,
	input  spoc_pkg::sum_t sum,
	output spoc_pkg::avg_t avg_s4,
	output logic           pos_s4
);

	logic                        neg;
	logic [spoc_pkg::X_W-1:0]    mag;
	logic [spoc_pkg::X_W-1:0]    x;

	logic [spoc_pkg::PROD_W-1:0] prod_s3;
	logic [spoc_pkg::X_W-1:0]    x_s3;
	logic                        neg_s3;
	logic                        pos_s3;

	logic [spoc_pkg::Q_W-1:0]    q_est;
	logic [spoc_pkg::X_W:0]      qn;
	logic [spoc_pkg::X_W:0]      rem;
	logic [spoc_pkg::Q_W-1:0]    q;
	logic [spoc_pkg::AVG_W-1:0]  qa;

	assign neg = sum[spoc_pkg::SUM_W-1];
	assign mag = neg ? unsigned'(spoc_pkg::X_W'(-sum)) : unsigned'(spoc_pkg::X_W'(sum));
	// round half away from zero on the magnitude
	assign x   = mag + spoc_pkg::HALF_N;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			prod_s3 <= spoc_pkg::PROD_W'(x) * spoc_pkg::PROD_W'(spoc_pkg::DIV_RECIP);
			x_s3    <= x;
			neg_s3  <= neg;
			pos_s3  <= !neg && (sum != '0);
		end
	end

	assign q_est = prod_s3[spoc_pkg::X_W +: spoc_pkg::Q_W];
	assign qn    = (spoc_pkg::X_W + 1)'((spoc_pkg::X_W + 1)'(q_est) * spoc_pkg::DIV_N);
	assign rem   = {1'b0, x_s3} - qn;
	assign q     = (rem >= spoc_pkg::DIV_N) ? q_est + spoc_pkg::Q_W'(1) : q_est;
	assign qa    = spoc_pkg::AVG_W'(q);

	always_ff @(posedge clk) begin
		if (en_s4) begin
			avg_s4 <= neg_s3 ? -signed'(qa) : signed'(qa);
			pos_s4 <= pos_s3;
		end
	end

endmodule

// ----- rtl/spoc_offset.sv -----
// ----------------------------------------------------------------------------
// spoc_offset
// per-orientation offset rule and saturation of a finished run
// ----------------------------------------------------------------------------
module spoc_offset (
	input  spoc_pkg::spoc_res_t          res,
	input  spoc_pkg::avg_t               avg [spoc_pkg::AXES],
	input  logic [spoc_pkg::AXES-1:0]    pos,
	output spoc_pkg::offset_t            off [spoc_pkg::AXES],
	output logic [spoc_pkg::MASK_W-1:0]  mask
);

	logic signed [spoc_pkg::CALC_W-1:0] av   [spoc_pkg::AXES];
	logic signed [spoc_pkg::CALC_W-1:0] half [spoc_pkg::AXES];
	logic signed [spoc_pkg::CALC_W-1:0] calc [spoc_pkg::AXES];

	function automatic spoc_pkg::offset_t sat(input logic signed [spoc_pkg::CALC_W-1:0] v);
		if (v > spoc_pkg::OFF_LIM_P) begin
			sat = spoc_pkg::OFF_W'(spoc_pkg::OFF_LIM_P);
		end else if (v < spoc_pkg::OFF_LIM_M) begin
			sat = spoc_pkg::OFF_W'(spoc_pkg::OFF_LIM_M);
		end else begin
			sat = spoc_pkg::OFF_W'(v);
		end
	endfunction

	for (genvar g = 0; g < spoc_pkg::AXES; g++) begin : g_axis
		assign av[g]   = spoc_pkg::CALC_W'(avg[g]);
		// half-turn reference follows the sign of the sum
		assign half[g] = pos[g] ? spoc_pkg::DEG_P180 : spoc_pkg::DEG_M180;
		assign off[g]  = sat(calc[g]);
	end

	always_comb begin
		for (int i = 0; i < spoc_pkg::AXES; i++) begin
			calc[i] = '0;
		end
		mask = spoc_pkg::MASK_NONE;
		if (res.status == spoc_pkg::ST_COMPLETE) begin
			case (res.ori)
				spoc_pkg::ORI_Z_P90: begin
					calc[spoc_pkg::AXIS_Z] = spoc_pkg::DEG_P90 - av[spoc_pkg::AXIS_Z];
					mask = spoc_pkg::MASK_Z;
				end
				spoc_pkg::ORI_Z_ZERO: begin
					calc[spoc_pkg::AXIS_Z] = -av[spoc_pkg::AXIS_Z];
					mask = spoc_pkg::MASK_Z;
				end
				spoc_pkg::ORI_XY_ZERO: begin
					calc[spoc_pkg::AXIS_X] = -av[spoc_pkg::AXIS_X];
					calc[spoc_pkg::AXIS_Y] = -av[spoc_pkg::AXIS_Y];
					mask = spoc_pkg::MASK_XY;
				end
				spoc_pkg::ORI_Z_M90: begin
					calc[spoc_pkg::AXIS_Z] = spoc_pkg::DEG_M90 - av[spoc_pkg::AXIS_Z];
					mask = spoc_pkg::MASK_Z;
				end
				spoc_pkg::ORI_Z_HALF: begin
					calc[spoc_pkg::AXIS_Z] = half[spoc_pkg::AXIS_Z] - av[spoc_pkg::AXIS_Z];
					mask = spoc_pkg::MASK_Z;
				end
				spoc_pkg::ORI_XY_HALF: begin
					calc[spoc_pkg::AXIS_X] = half[spoc_pkg::AXIS_X] - av[spoc_pkg::AXIS_X];
					calc[spoc_pkg::AXIS_Y] = half[spoc_pkg::AXIS_Y] - av[spoc_pkg::AXIS_Y];
					mask = spoc_pkg::MASK_XY;
				end
				// codes six and seven complete with no offsets
				default: mask = spoc_pkg::MASK_NONE;
			endcase
		end
	end

endmodule

// ----- rtl/stable_pose_offset_calibrator.sv -----
// ----------------------------------------------------------------------------
// stable_pose_offset_calibrator
// averages a still run of angle samples and emits per-orientation offsets
// ----------------------------------------------------------------------------
// usage
//   s_* carries one angle sample per word: three axis angles and the code of
//   the face pointing to gravity. m_* returns exactly one word per sample: the
//   status in tuser (collecting, restarted on motion, aborted, complete) and,
//   on completion, the offsets and their valid mask in tdata.
//   cfg_we / cfg_wdata write the motion threshold; write only while idle.
//   a sample moves from the input register through the run-state register,
//   the averaging divide (a two-stage reciprocal multiply per axis) and the
//   output register. throughput: one sample per cycle unless m_tready stalls
//   the output; the run state is updated between the input and next stages.
//   five register stages each hold a word, so input keeps flowing while a
//   result waits; when m_tready stays low the pipeline fills and s_tready
//   drops once all five stages hold words.
//   reset clears the run, the references and the pipeline, and loads the
//   threshold with 1311 (about 0.02 degree).
// ----------------------------------------------------------------------------
`include "stable_pose_offset_calibrator_defines.svh"

module stable_pose_offset_calibrator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [spoc_pkg::THR_W-1:0]       cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// angle_x, angle_y, angle_z, orientation, zero fill
	input  logic [spoc_pkg::IN_DATA_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// offset_x, offset_y, offset_z, offset_mask, zero fill
	output logic [spoc_pkg::OUT_DATA_W-1:0]  m_tdata,
	// status
	output logic [spoc_pkg::STATUS_W-1:0]    m_tuser
);

	logic [spoc_pkg::THR_W-1:0] threshold_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	spoc_pkg::angle_t           ang_s1 [spoc_pkg::AXES];
	logic [spoc_pkg::ORI_W-1:0] ori_s1;

	spoc_pkg::spoc_res_t core_res;
	spoc_pkg::sum_t      core_sum [spoc_pkg::AXES];

	spoc_pkg::spoc_res_t res_s2, res_s3, res_s4;
	spoc_pkg::sum_t      sum_s2 [spoc_pkg::AXES];

	spoc_pkg::avg_t            avg_s4 [spoc_pkg::AXES];
	logic [spoc_pkg::AXES-1:0] pos_s4;

	spoc_pkg::offset_t           off_nxt [spoc_pkg::AXES];
	logic [spoc_pkg::MASK_W-1:0] mask_nxt;

	spoc_pkg::offset_t           off_s5 [spoc_pkg::AXES];
	logic [spoc_pkg::MASK_W-1:0] mask_s5;
	spoc_pkg::spoc_status_t      status_s5;

	// a stage takes a word when empty or when its word moves on
	assign rdy_s5 = !v_s5 || m_tready;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= spoc_pkg::THR_RESET;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (cfg_we) begin
				threshold_q <= cfg_wdata;
			end
			if (rdy_s1) v_s1 <= s_tvalid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			for (int i = 0; i < spoc_pkg::AXES; i++) begin
				ang_s1[i] <= s_tdata[i * spoc_pkg::ANGLE_W +: spoc_pkg::ANGLE_W];
			end
			ori_s1 <= s_tdata[spoc_pkg::ORI_LSB +: spoc_pkg::ORI_W];
		end
		if (rdy_s2) begin
			res_s2 <= core_res;
			for (int i = 0; i < spoc_pkg::AXES; i++) begin
				sum_s2[i] <= core_sum[i];
			end
		end
		if (rdy_s3) res_s3 <= res_s2;
		if (rdy_s4) res_s4 <= res_s3;
		if (rdy_s5) begin
			status_s5 <= res_s4.status;
			mask_s5   <= mask_nxt;
			for (int i = 0; i < spoc_pkg::AXES; i++) begin
				off_s5[i] <= off_nxt[i];
			end
		end
	end

	spoc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (v_s1 && rdy_s2),
		.threshold (threshold_q),
		.angle     (ang_s1),
		.ori       (ori_s1),
		.res       (core_res),
		.sum_out   (core_sum)
	);

	for (genvar g = 0; g < spoc_pkg::AXES; g++) begin : g_div
		spoc_div u_div (
			.clk    (clk),
			.en_s3  (rdy_s3),
			.en_s4  (rdy_s4),
			.sum    (sum_s2[g]),
			.avg_s4 (avg_s4[g]),
			.pos_s4 (pos_s4[g])
		);
	end

	spoc_offset u_offset (
		.res  (res_s4),
		.avg  (avg_s4),
		.pos  (pos_s4),
		.off  (off_nxt),
		.mask (mask_nxt)
	);

	always_comb begin
		m_tdata = '0;
		for (int i = 0; i < spoc_pkg::AXES; i++) begin
			m_tdata[i * spoc_pkg::OFF_W +: spoc_pkg::OFF_W] = off_s5[i];
		end
		m_tdata[spoc_pkg::MASK_LSB +: spoc_pkg::MASK_W] = mask_s5;
	end

	assign m_tvalid = v_s5;
	assign m_tuser  = status_s5;

	`SPOC_ASSERT_IMP(a_ready_when_drained, !m_tvalid, s_tready)
	`SPOC_ASSERT_NXT(a_accept_fills_s1, s_tvalid && s_tready, v_s1)
	`SPOC_ASSERT_IMP(a_no_offsets_unless_done, m_tvalid && (m_tuser != spoc_pkg::ST_COMPLETE), m_tdata == '0)
	`SPOC_ASSERT_IMP(a_mask_pattern, m_tvalid && (mask_s5 != spoc_pkg::MASK_NONE), (mask_s5 == spoc_pkg::MASK_XY) || (mask_s5 == spoc_pkg::MASK_Z))

endmodule
